// ===== rtl/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// Serial frame deframer package
// Shared constants, framing bytes and state machine types for the deframer.
// ----------------------------------------------------------------------------
package sfd_pkg;

   localparam int BYTE_W           = 8;
   localparam int SLOT_INDEX_W     = 5;
   localparam int MAX_RESULTS      = 32;
   localparam int BUFFER_DEPTH_DEF = 32;

   // Framing bytes.
   localparam logic [BYTE_W-1:0] BYTE_SYNC = 8'hFF;
   localparam logic [BYTE_W-1:0] BYTE_ZERO = 8'h00;

   // The length byte counts six header and trailer bytes besides the payload.
   localparam int HEADER_OVERHEAD = 6;
   // Buffer slot holding the sequence number, and first payload slot.
   localparam int SEQ_SLOT        = 2;
   localparam int PAYLOAD_BASE    = 3;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'd0,
      PH_SYNC0   = 3'd1,
      PH_SYNC1   = 3'd2,
      PH_LENGTH  = 3'd3,
      PH_PAYLOAD = 3'd4,
      PH_TAIL0   = 3'd5,
      PH_TAIL1   = 3'd6
   } phase_type;

   typedef enum logic [1:0] {
      EM_IDLE = 2'd0,
      EM_READ = 2'd1,
      EM_LOAD = 2'd2,
      EM_WAIT = 2'd3
   } emit_state_type;

endpackage

// ===== rtl/serial_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// Serial frame deframer
// Recovers FF 00 FF framed packets from a serial byte stream and emits the
// assembled frame buffer one byte per result transaction.
// ----------------------------------------------------------------------------
// Usage:
// The req channel carries one received serial byte per transaction. Every
// byte that does not complete a frame is accepted without a stall and gives
// no result. A frame is FF 00 FF, a length byte L, max(1, L-6) payload bytes
// and two closing FF bytes (other bytes after the payload, even between the
// FFs, are skipped). The byte that completes a frame starts the emission of
// the frame buffer on the rsp channel: min(BUFFER_DEPTH, 32) transactions,
// slot 0 first, with tlast on the final one and tuser set when payload bytes
// fell off the end of the buffer. Slot 2 holds a wrapping frame sequence
// number, payload starts at slot 3, and slots never written read as zero.
// The buffer lives in a RAM with a registered read port, so each result
// passes through three steps: address, load and handshake. While a frame
// is emitted req_tready is low; a stalled receiver simply holds the
// current result in the output register. Reset returns the deframer to the
// hunt for the first FF and zeroes the sequence number.
// ----------------------------------------------------------------------------
module serial_frame_deframer #(
   parameter int BUFFER_DEPTH = sfd_pkg::BUFFER_DEPTH_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   // Input stream, tdata: rx_byte[7:0].
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [sfd_pkg::BYTE_W-1:0]  req_tdata,
   // Result stream, tdata: slot_index[4:0], slot_value[12:5], zero pad[15:13].
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [15:0]                 rsp_tdata,
   // tuser: truncated[0].
   output logic                        rsp_tuser,
   output logic                        rsp_tlast
);

   import sfd_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int FW = $clog2(BUFFER_DEPTH + 1);
   localparam int EmitCount = (BUFFER_DEPTH < MAX_RESULTS) ? BUFFER_DEPTH : MAX_RESULTS;

   // Deframer state.
   phase_type        phase_ff, phase_in;
   logic [7:0]       frame_length_ff, frame_length_in;
   logic [7:0]       payload_count_ff, payload_count_in;
   logic [7:0]       sequence_ff, sequence_in;
   logic             overflow_ff, overflow_in;
   // One past the highest payload slot written since the length byte.
   // Slots from the payload base up to here hold data; others read as zero.
   logic [FW-1:0]    fill_ff, fill_in;

   // Emission state.
   emit_state_type   emit_ff, emit_in;
   logic [AW-1:0]    slot_ff, slot_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [SLOT_INDEX_W-1:0] rsp_index_ff, rsp_index_in;
   logic [BYTE_W-1:0] rsp_value_ff, rsp_value_in;
   logic             rsp_last_ff, rsp_last_in;

   // Buffer RAM port.
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [BYTE_W-1:0] ram_wr_data;
   logic [BYTE_W-1:0] ram_rd_data;

   logic             req_fire;
   logic [8:0]       payload_idx;
   logic             payload_fits;
   logic             payload_done;
   logic [FW-1:0]    slot_ext;
   logic             slot_live;
   logic             slot_final;

   // The RAM is written only while bytes are accepted and read only while a
   // frame is emitted, and the two never overlap, so no forwarding is needed.
   sfd_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (BUFFER_DEPTH)
   ) u_buffer (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   assign req_tready = (emit_ff == EM_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   assign payload_idx  = {1'b0, payload_count_ff} + 9'(PAYLOAD_BASE);
   assign payload_fits = payload_idx < 9'(BUFFER_DEPTH);
   // Payload ends once count + 1 + overhead reaches the length byte.
   assign payload_done = ({1'b0, payload_count_ff} + 9'd1 + 9'(HEADER_OVERHEAD))
                         >= {1'b0, frame_length_ff};

   assign slot_ext   = FW'(slot_ff);
   assign slot_live  = (slot_ff == AW'(SEQ_SLOT)) ||
                       ((slot_ext >= FW'(PAYLOAD_BASE)) && (slot_ext < fill_ff));
   assign slot_final = (slot_ff == AW'(EmitCount - 1));

   always_comb begin
      phase_in         = phase_ff;
      frame_length_in  = frame_length_ff;
      payload_count_in = payload_count_ff;
      sequence_in      = sequence_ff;
      overflow_in      = overflow_ff;
      fill_in          = fill_ff;
      emit_in          = emit_ff;
      slot_in          = slot_ff;
      rsp_valid_in     = rsp_valid_ff;
      rsp_index_in     = rsp_index_ff;
      rsp_value_in     = rsp_value_ff;
      rsp_last_in      = rsp_last_ff;
      ram_wr_en        = 1'b0;
      ram_wr_addr      = payload_idx[AW-1:0];
      ram_wr_data      = req_tdata;

      if (req_fire) begin
         unique case (phase_ff)
            PH_SYNC0: begin
               if (req_tdata == BYTE_ZERO) begin
                  phase_in = PH_SYNC1;
               end else if (req_tdata == BYTE_SYNC) begin
                  phase_in = PH_SYNC0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_SYNC1: begin
               phase_in = (req_tdata == BYTE_SYNC) ? PH_LENGTH : PH_HUNT;
            end
            PH_LENGTH: begin
               // Start a fresh buffer: only the sequence slot holds data.
               frame_length_in  = req_tdata;
               ram_wr_en        = 1'b1;
               ram_wr_addr      = AW'(SEQ_SLOT);
               ram_wr_data      = sequence_ff;
               sequence_in      = sequence_ff + 8'd1;
               overflow_in      = 1'b0;
               payload_count_in = 8'd0;
               fill_in          = FW'(PAYLOAD_BASE);
               phase_in         = PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
               if (payload_fits) begin
                  ram_wr_en = 1'b1;
                  fill_in   = FW'(payload_idx + 9'd1);
               end else begin
                  overflow_in = 1'b1;
               end
               payload_count_in = payload_count_ff + 8'd1;
               if (payload_done) begin
                  payload_count_in = 8'd0;
                  phase_in         = PH_TAIL0;
               end
            end
            PH_TAIL0: begin
               if (req_tdata == BYTE_SYNC) begin
                  phase_in = PH_TAIL1;
               end
            end
            PH_TAIL1: begin
               if (req_tdata == BYTE_SYNC) begin
                  phase_in = PH_HUNT;
                  slot_in  = '0;
                  emit_in  = EM_READ;
               end
            end
            default: begin
               phase_in = (req_tdata == BYTE_SYNC) ? PH_SYNC0 : PH_HUNT;
            end
         endcase
      end

      unique case (emit_ff)
         EM_IDLE: begin
         end
         EM_READ: begin
            // RAM address is the current slot; data is ready next cycle.
            emit_in = EM_LOAD;
         end
         EM_LOAD: begin
            rsp_valid_in = 1'b1;
            rsp_index_in = SLOT_INDEX_W'(slot_ff);
            rsp_value_in = slot_live ? ram_rd_data : BYTE_ZERO;
            rsp_last_in  = slot_final;
            emit_in      = EM_WAIT;
         end
         EM_WAIT: begin
            if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_ff) begin
                  emit_in = EM_IDLE;
               end else begin
                  slot_in = slot_ff + AW'(1);
                  emit_in = EM_READ;
               end
            end
         end
         default: begin
            emit_in = EM_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         frame_length_ff  <= 8'd0;
         payload_count_ff <= 8'd0;
         sequence_ff      <= 8'd0;
         overflow_ff      <= 1'b0;
         fill_ff          <= '0;
         emit_ff          <= EM_IDLE;
         slot_ff          <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         phase_ff         <= phase_in;
         frame_length_ff  <= frame_length_in;
         payload_count_ff <= payload_count_in;
         sequence_ff      <= sequence_in;
         overflow_ff      <= overflow_in;
         fill_ff          <= fill_in;
         emit_ff          <= emit_in;
         slot_ff          <= slot_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_value_ff, rsp_index_ff};
   // No input is taken during emission, so the flag is stable for the frame.
   assign rsp_tuser  = overflow_ff;
   assign rsp_tlast  = rsp_last_ff;

   // Input and output never handshake in the same emission window.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a result is pending");

   // The final result sits at the last emitted slot.
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tdata[4:0] == SLOT_INDEX_W'(EmitCount - 1))
      else $error("tlast on a slot other than the final one");

   // Taking the final result returns the block to accepting bytes.
   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready)
      else $error("block did not resume after the final result");

   // The deframer phase moves only on an accepted byte.
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_tvalid && req_tready) |=> $stable(phase_ff))
      else $error("phase changed without an input transaction");

endmodule

// ===== rtl/sfd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data appears in the cycle
// after the address.
// ----------------------------------------------------------------------------
module sfd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
